>>> rtl/tslsa_pkg.sv
// Shared types, register codes and arithmetic helpers for the twist slew limiter.
package tslsa_pkg;

   localparam int AXES        = 6;
   localparam int AX_W        = 3;
   localparam int DATA_W      = 16;
   localparam int THR_W       = 15;
   localparam int CSR_IDX_W   = 4;
   localparam int PROD_W      = 32;
   localparam int GAIN_SHIFT  = 12;
   localparam int NEG_AXIS    = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_SLEW_THRESHOLD = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SLEW_STEP      = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_LIN_X     = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_LIN_Y     = 4'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_LIN_Z     = 4'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_ANG_X     = 4'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_ANG_Y     = 4'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_ANG_Z     = 4'd7;

   localparam logic [THR_W-1:0]         THRESHOLD_RESET = 15'd154;
   localparam logic [THR_W-1:0]         STEP_RESET      = 15'd154;
   localparam logic signed [DATA_W-1:0] GAIN_RESET      = 16'sd4096;

   typedef struct packed {
      logic                     done;
      logic signed [DATA_W-1:0] quo;
   } div_res_type;

   // Clamp a wide signed value to the 16-bit signed range.
   function automatic logic signed [DATA_W-1:0] sat16(input logic signed [PROD_W-1:0] v);
      logic signed [DATA_W-1:0] r;
      if (v > 32'sd32767) begin
         r = 16'sh7fff;
      end else if (v < -32'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[DATA_W-1:0];
      end
      return r;
   endfunction

endpackage

>>> rtl/tslsa_if.sv
// Valid/ready channel interfaces for commands, results and register writes.
interface tslsa_req_if;
   logic                      valid;
   logic                      ready;
   logic signed [15:0]        lin_x;
   logic signed [15:0]        lin_y;
   logic signed [15:0]        lin_z;
   logic signed [15:0]        ang_x;
   logic signed [15:0]        ang_y;
   logic signed [15:0]        ang_z;
   modport source (output valid, lin_x, lin_y, lin_z, ang_x, ang_y, ang_z, input ready);
   modport sink (input valid, lin_x, lin_y, lin_z, ang_x, ang_y, ang_z, output ready);
endinterface

interface tslsa_rsp_if;
   logic                      valid;
   logic                      ready;
   logic signed [15:0]        out_lin_x;
   logic signed [15:0]        out_lin_y;
   logic signed [15:0]        out_lin_z;
   logic signed [15:0]        out_ang_x;
   logic signed [15:0]        out_ang_y;
   logic signed [15:0]        out_ang_z;
   modport source (output valid, out_lin_x, out_lin_y, out_lin_z, out_ang_x, out_ang_y,
                   out_ang_z, input ready);
   modport sink (input valid, out_lin_x, out_lin_y, out_lin_z, out_ang_x, out_ang_y,
                 out_ang_z, output ready);
endinterface

interface tslsa_csr_if;
   logic              valid;
   logic              ready;
   logic [3:0]        index;
   logic [15:0]       data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/tslsa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module tslsa_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);
   logic [WIDTH-1:0] mem [0:DEPTH-1];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

>>> rtl/tslsa_div.sv
// Radix-2 restoring divider: signed window sum by unsigned sample count, toward zero.
module tslsa_div #(
   parameter int SUM_W = 21,
   parameter int CNT_W = 4
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic signed [SUM_W-1:0]   dividend,
   input  logic [CNT_W-1:0]          divisor,
   output tslsa_pkg::div_res_type    res
);
   import tslsa_pkg::*;

   localparam int STEP_W = $clog2(SUM_W + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic              neg_ff, neg_in;
   logic [STEP_W-1:0] steps_ff, steps_in;
   logic [CNT_W-1:0]  den_ff, den_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [SUM_W-1:0]  quo_ff, quo_in;
   logic [CNT_W:0]    rem_shift;
   logic              fits;
   logic [DATA_W-1:0] qmag;

   assign rem_shift = {rem_ff, quo_ff[SUM_W-1]};
   assign fits      = rem_shift >= {1'b0, den_ff};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      neg_in   = neg_ff;
      steps_in = steps_ff;
      den_in   = den_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      if (start) begin
         busy_in  = 1'b1;
         neg_in   = dividend[SUM_W-1];
         steps_in = STEP_W'(SUM_W);
         den_in   = divisor;
         rem_in   = '0;
         quo_in   = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
      end else if (busy_ff) begin
         rem_in   = fits ? CNT_W'(rem_shift - {1'b0, den_ff}) : rem_shift[CNT_W-1:0];
         quo_in   = {quo_ff[SUM_W-2:0], fits};
         steps_in = steps_ff - 1'b1;
         if (steps_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
      end
      neg_ff   <= neg_in;
      steps_ff <= steps_in;
      den_ff   <= den_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
   end

   // An average of 16-bit samples always fits 16 bits, so the low bits suffice.
   assign qmag     = quo_ff[DATA_W-1:0];
   assign res.done = done_ff;
   assign res.quo  = neg_ff ? -$signed(qmag) : $signed(qmag);
endmodule

>>> rtl/twist_slew_limit_scale_average_core.sv
// Six-axis velocity conditioner top level: slew limit, gain (ang_y and ang_z negated), moving average.
//
//   channel   beat moves                                 handshake
//   req_if    one six-axis command (Q7.8)                valid/ready
//   rsp_if    one limited, scaled, averaged command      valid/ready
//   csr_if    register index and write data              valid/ready (always ready)
//
// The axes run one after another through one slew/multiply/saturate path; each axis steps
// through ST_READ, ST_SLEW, ST_MUL, ST_SCALE and ST_ACCUM for the read-modify-write of its
// state and sample memories, then waits in ST_DIV on the shared divider. The window sum is
// SUM_W = 17 + clog2(WINDOW) bits wide (21 by default). The result register lets the next
// command beat be taken while a result waits; a second finished result holds the pipeline
// until the first one is taken. Synchronous reset returns the control registers to their
// reset values and clears the fill count and the per-axis state valid bits.
module twist_slew_limit_scale_average_core #(
   parameter int WINDOW = 10
) (
   input  logic         clock,
   input  logic         reset,
   tslsa_req_if.sink    req_if,
   tslsa_rsp_if.source  rsp_if,
   tslsa_csr_if.sink    csr_if
);
   import tslsa_pkg::*;

   localparam int CNT_W      = $clog2(WINDOW + 1);
   localparam int POS_W      = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int SUM_W      = 17 + $clog2(WINDOW);
   localparam int SAMP_DEPTH = AXES * WINDOW;
   localparam int SA_W       = $clog2(SAMP_DEPTH);
   localparam int STATE_W    = DATA_W + SUM_W;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_READ  = 3'd1;
   localparam logic [2:0] ST_SLEW  = 3'd2;
   localparam logic [2:0] ST_MUL   = 3'd3;
   localparam logic [2:0] ST_SCALE = 3'd4;
   localparam logic [2:0] ST_ACCUM = 3'd5;
   localparam logic [2:0] ST_DIV   = 3'd6;
   localparam logic [2:0] ST_DONE  = 3'd7;

   logic [2:0]                state_ff, state_in;
   logic [AX_W-1:0]           axis_ff, axis_in;
   logic [SA_W-1:0]           base_ff, base_in;
   logic [POS_W-1:0]          pos_ff, pos_in;
   logic [CNT_W-1:0]          fill_ff, fill_in;
   logic [AXES-1:0]           valid_ff, valid_in;
   logic [THR_W-1:0]          thr_ff;
   logic [THR_W-1:0]          step_ff;
   logic signed [DATA_W-1:0]  gain_ff [0:AXES-1];
   logic signed [DATA_W-1:0]  cmd_ff [0:AXES-1];
   logic signed [DATA_W-1:0]  res_ff [0:AXES-1];
   logic signed [DATA_W-1:0]  out_ff [0:AXES-1];
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0]  lim_ff, lim_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [DATA_W-1:0]  scl_ff, scl_in;

   logic                      req_beat;
   logic                      rsp_beat;
   logic                      full;
   logic [CNT_W-1:0]          count;
   logic                      load_out;

   logic [STATE_W-1:0]        st_rdata;
   logic [DATA_W-1:0]         samp_rdata;
   logic [SA_W-1:0]           samp_addr;
   logic                      st_wr, samp_wr, mem_rd;

   logic signed [DATA_W-1:0]  prev;
   logic signed [SUM_W-1:0]   sum_old, sum_new;
   logic signed [DATA_W:0]    diff;
   logic [DATA_W:0]           mag;
   logic signed [PROD_W-1:0]  step_up, step_dn;
   logic signed [DATA_W-1:0]  scl_pos;
   logic signed [PROD_W-1:0]  prod_shr;

   div_res_type               div_res;
   logic                      div_start;

   assign req_beat      = req_if.valid && req_if.ready;
   assign rsp_beat      = rsp_if.valid && rsp_if.ready;
   assign req_if.ready  = (state_ff == ST_IDLE);
   assign csr_if.ready  = 1'b1;

   assign full  = (fill_ff == CNT_W'(WINDOW));
   assign count = full ? CNT_W'(WINDOW) : fill_ff + 1'b1;

   // Register writes, to be issued only while the block is idle; the block leaves this rule to the user.
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff  <= THRESHOLD_RESET;
         step_ff <= STEP_RESET;
         for (int i = 0; i < AXES; i++) begin
            gain_ff[i] <= GAIN_RESET;
         end
      end else if (csr_if.valid && csr_if.ready) begin
         unique case (csr_if.index)
            CSR_SLEW_THRESHOLD: thr_ff     <= csr_if.data[THR_W-1:0];
            CSR_SLEW_STEP:      step_ff    <= csr_if.data[THR_W-1:0];
            CSR_GAIN_LIN_X:     gain_ff[0] <= csr_if.data;
            CSR_GAIN_LIN_Y:     gain_ff[1] <= csr_if.data;
            CSR_GAIN_LIN_Z:     gain_ff[2] <= csr_if.data;
            CSR_GAIN_ANG_X:     gain_ff[3] <= csr_if.data;
            CSR_GAIN_ANG_Y:     gain_ff[4] <= csr_if.data;
            CSR_GAIN_ANG_Z:     gain_ff[5] <= csr_if.data;
            default: begin
            end
         endcase
      end
   end

   // Per-axis previous limited value and window sum share one memory row.
   tslsa_ram #(.WIDTH(STATE_W), .DEPTH(AXES)) u_state_ram (
      .clock   (clock),
      .wr_en   (st_wr),
      .wr_addr (axis_ff),
      .wr_data ({lim_ff, sum_new}),
      .rd_en   (mem_rd),
      .rd_addr (axis_ff),
      .rd_data (st_rdata)
   );

   tslsa_ram #(.WIDTH(DATA_W), .DEPTH(SAMP_DEPTH)) u_samp_ram (
      .clock   (clock),
      .wr_en   (samp_wr),
      .wr_addr (samp_addr),
      .wr_data (scl_ff),
      .rd_en   (mem_rd),
      .rd_addr (samp_addr),
      .rd_data (samp_rdata)
   );

   tslsa_div #(.SUM_W(SUM_W), .CNT_W(CNT_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_new),
      .divisor  (count),
      .res      (div_res)
   );

   assign samp_addr = base_ff + SA_W'(pos_ff);
   assign mem_rd    = (state_ff == ST_READ);
   assign st_wr     = (state_ff == ST_ACCUM);
   assign samp_wr   = (state_ff == ST_ACCUM);
   assign div_start = (state_ff == ST_ACCUM);

   // A row never written since reset reads as zero.
   assign prev    = valid_ff[axis_ff] ? $signed(st_rdata[STATE_W-1 -: DATA_W]) : '0;
   assign sum_old = valid_ff[axis_ff] ? $signed(st_rdata[SUM_W-1:0]) : '0;

   // Slew limit.
   always_comb begin
      diff    = (DATA_W+1)'(cmd_ff[axis_ff]) - (DATA_W+1)'(prev);
      mag     = diff[DATA_W] ? (DATA_W+1)'(-diff) : (DATA_W+1)'(diff);
      step_up = PROD_W'(prev) + $signed({17'd0, step_ff});
      step_dn = PROD_W'(prev) - $signed({17'd0, step_ff});
      if (mag > {2'b00, thr_ff}) begin
         lim_in = diff[DATA_W] ? sat16(step_dn) : sat16(step_up);
      end else begin
         lim_in = cmd_ff[axis_ff];
      end
   end

   assign prod_in  = PROD_W'(lim_ff) * PROD_W'(gain_ff[axis_ff]);
   assign prod_shr = prod_ff >>> GAIN_SHIFT;
   assign scl_pos  = sat16(prod_shr);
   assign scl_in   = (axis_ff >= AX_W'(NEG_AXIS)) ? sat16(-PROD_W'(scl_pos)) : scl_pos;

   assign sum_new = sum_old - (full ? SUM_W'($signed(samp_rdata)) : SUM_W'(0))
                    + SUM_W'(scl_ff);

   assign load_out = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_if.ready);

   always_comb begin
      state_in     = state_ff;
      axis_in      = axis_ff;
      base_in      = base_ff;
      pos_in       = pos_ff;
      fill_in      = fill_ff;
      valid_in     = valid_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_beat) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               axis_in  = '0;
               base_in  = '0;
               state_in = ST_READ;
            end
         end
         ST_READ:  state_in = ST_SLEW;
         ST_SLEW:  state_in = ST_MUL;
         ST_MUL:   state_in = ST_SCALE;
         ST_SCALE: state_in = ST_ACCUM;
         ST_ACCUM: begin
            valid_in[axis_ff] = 1'b1;
            state_in          = ST_DIV;
         end
         ST_DIV: begin
            if (div_res.done) begin
               if (axis_ff == AX_W'(AXES - 1)) begin
                  state_in = ST_DONE;
               end else begin
                  axis_in  = axis_ff + 1'b1;
                  base_in  = base_ff + SA_W'(WINDOW);
                  state_in = ST_READ;
               end
            end
         end
         ST_DONE: begin
            if (load_out) begin
               rsp_valid_in = 1'b1;
               fill_in      = count;
               pos_in       = ((POS_W+1)'(pos_ff) + 1'b1 >= (POS_W+1)'(WINDOW)) ?
                              '0 : pos_ff + 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         axis_ff      <= '0;
         base_ff      <= '0;
         pos_ff       <= '0;
         fill_ff      <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         axis_ff      <= axis_in;
         base_ff      <= base_in;
         pos_ff       <= pos_in;
         fill_ff      <= fill_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         cmd_ff[0] <= req_if.lin_x;
         cmd_ff[1] <= req_if.lin_y;
         cmd_ff[2] <= req_if.lin_z;
         cmd_ff[3] <= req_if.ang_x;
         cmd_ff[4] <= req_if.ang_y;
         cmd_ff[5] <= req_if.ang_z;
      end
      if (state_ff == ST_SLEW) begin
         lim_ff <= lim_in;
      end
      if (state_ff == ST_MUL) begin
         prod_ff <= prod_in;
      end
      if (state_ff == ST_SCALE) begin
         scl_ff <= scl_in;
      end
      if (state_ff == ST_DIV && div_res.done) begin
         res_ff[axis_ff] <= div_res.quo;
      end
      if (load_out) begin
         for (int i = 0; i < AXES; i++) begin
            out_ff[i] <= res_ff[i];
         end
      end
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.out_lin_x = out_ff[0];
   assign rsp_if.out_lin_y = out_ff[1];
   assign rsp_if.out_lin_z = out_ff[2];
   assign rsp_if.out_ang_x = out_ff[3];
   assign rsp_if.out_ang_y = out_ff[4];
   assign rsp_if.out_ang_z = out_ff[5];
endmodule

>>> rtl/tslsa_chk.sv
// Port-level checker for the twist slew limiter, bound to the top level.
module tslsa_chk (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [95:0] rsp_payload
);
   logic       req_beat;
   logic       rsp_beat;
   logic [1:0] pending_ff, pending_in;

   assign req_beat = req_valid && req_ready;
   assign rsp_beat = rsp_valid && rsp_ready;

   // Commands taken whose results have not yet been delivered.
   always_comb begin
      pending_in = pending_ff;
      if (req_beat && !rsp_beat) begin
         pending_in = pending_ff + 1'b1;
      end else if (rsp_beat && !req_beat) begin
         pending_in = pending_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat withdrawn before it was taken");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_payload))
      else $error("result payload changed while stalled");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_beat |-> pending_ff != 2'd0)
      else $error("result delivered with no command outstanding");

   a_depth: assert property (@(posedge clock) disable iff (reset)
      pending_ff != 2'd3)
      else $error("more than two commands in flight");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> !req_ready)
      else $error("command taken while the previous one is still being processed");
endmodule

bind twist_slew_limit_scale_average_core tslsa_chk u_tslsa_chk (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_if.valid),
   .req_ready   (req_if.ready),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .rsp_payload ({rsp_if.out_lin_x, rsp_if.out_lin_y, rsp_if.out_lin_z,
                  rsp_if.out_ang_x, rsp_if.out_ang_y, rsp_if.out_ang_z})
);
